FILE: rtl/psyn_pkg.sv
// ----------------------------------------------------------------------------
// psyn_pkg
// Shared types, constants and helpers of the plucked string voice.
// ----------------------------------------------------------------------------
package psyn_pkg;

   localparam int MAX_PERIOD = 1024;
   localparam int MIN_PERIOD = 8;
   localparam int ADDR_W     = $clog2(MAX_PERIOD);
   localparam int PER_W      = 11;
   localparam int SMP_W      = 16;
   localparam int COEF_W     = 16;
   localparam int OPND_W     = 18;
   localparam int PROD_W     = 2 * OPND_W;

   localparam logic [1:0] REG_PERIOD  = 2'd0;
   localparam logic [1:0] REG_TONE    = 2'd1;
   localparam logic [1:0] REG_DAMPING = 2'd2;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   localparam logic [PER_W-1:0]  PERIOD_RESET  = PER_W'(100);
   localparam logic [COEF_W-1:0] TONE_RESET    = COEF_W'(27525);
   localparam logic [COEF_W-1:0] DAMPING_RESET = COEF_W'(65000);

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic enable;
      logic accumulate;
   } mac_ctl_type;

   // clamp a 20-bit signed value to Q1.15
   function automatic logic signed [SMP_W-1:0] sat16(input logic signed [19:0] v);
      logic signed [19:0] hi;
      logic signed [19:0] lo;
      begin
         hi = 20'sd32767;
         lo = -20'sd32768;
         if (v > hi) begin
            sat16 = 16'sh7fff;
         end else if (v < lo) begin
            sat16 = 16'sh8000;
         end else begin
            sat16 = v[SMP_W-1:0];
         end
      end
   endfunction

endpackage

FILE: rtl/plucked_string_synth_core.sv
// ----------------------------------------------------------------------------
// plucked_string_synth_core
// Karplus-Strong string voice built round one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// After reset the block sweeps zeros through the 1024-entry delay line, one
// entry per cycle, and keeps req_tready low until the sweep is done. A load
// transfer (tuser 0) writes its sample in the cycle it is accepted and the
// block is ready again in the next cycle. A step transfer (tuser 1) goes
// through one memory read, three passes through the single 18x18 multiplier
// (tone term, lowpass term, damping) and one write-back step that also loads
// the result register before the block is ready again. The write-back
// waits while an earlier result has not yet been taken on rsp_.
// Configuration writes are taken at any time but should only be made idle.
module plucked_string_synth_core
   import psyn_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data,
   // input items
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] excitation
   input  logic                     req_tuser,   // [0] kind
   // results
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata    // [15:0] out_sample
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MUL1  = 3'd3;
   localparam logic [2:0] ST_MUL2  = 3'd4;
   localparam logic [2:0] ST_MUL3  = 3'd5;
   localparam logic [2:0] ST_WB    = 3'd6;

   logic [2:0]              state_ff, state_in;
   logic [PER_W-1:0]        period_ff;
   logic [COEF_W-1:0]       tone_ff, damping_ff;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]       rd_pos_ff, rd_pos_in;
   logic [ADDR_W-1:0]       ld_pos_ff, ld_pos_in;
   logic signed [SMP_W-1:0] prior_ff, prior_in;
   logic signed [SMP_W-1:0] cur_ff, cur_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SMP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic [PER_W-1:0]        eff_period;
   logic [ADDR_W-1:0]       ld_adj, rd_adj;
   logic [PER_W-1:0]        ld_next, rd_next;
   logic                    req_fire, wb_fire;

   mac_ctl_type             mac_ctl;
   logic signed [OPND_W-1:0] mac_a, mac_b;
   logic signed [PROD_W-1:0] mac_acc;

   logic                    mem_en, mem_we;
   logic [ADDR_W-1:0]       mem_addr;
   logic signed [SMP_W-1:0] mem_wdata, mem_rdata;
   logic signed [SMP_W-1:0] y_sat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         tone_ff    <= TONE_RESET;
         damping_ff <= DAMPING_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PERIOD:  period_ff  <= csr_data[PER_W-1:0];
            REG_TONE:    tone_ff    <= csr_data;
            REG_DAMPING: damping_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (period_ff < PER_W'(MIN_PERIOD)) begin
         eff_period = PER_W'(MIN_PERIOD);
      end else if (period_ff > PER_W'(MAX_PERIOD)) begin
         eff_period = PER_W'(MAX_PERIOD);
      end else begin
         eff_period = period_ff;
      end
   end

   // positions left beyond a lowered period restart at zero
   assign ld_adj  = ({1'b0, ld_pos_ff} >= eff_period) ? '0 : ld_pos_ff;
   assign rd_adj  = ({1'b0, rd_pos_ff} >= eff_period) ? '0 : rd_pos_ff;
   assign ld_next = {1'b0, ld_adj} + PER_W'(1);
   assign rd_next = {1'b0, rd_pos_ff} + PER_W'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wb_fire    = (state_ff == ST_WB) && (!rsp_valid_ff || rsp_tready);

   // lowpass output floor(acc / 2^16) and damped sample
   assign y_sat = sat16(mac_acc[PROD_W-1:16]);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rd_pos_in    = rd_pos_ff;
      ld_pos_in    = ld_pos_ff;
      prior_in     = prior_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mac_ctl      = '0;
      mac_a        = '0;
      mac_b        = '0;
      mem_en       = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = rd_pos_ff;
      mem_wdata    = y_sat;
      case (state_ff)
         ST_CLEAR: begin
            mem_en      = 1'b1;
            mem_we      = 1'b1;
            mem_addr    = clr_addr_ff;
            mem_wdata   = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_PERIOD - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == KIND_LOAD) begin
                  mem_en    = 1'b1;
                  mem_we    = 1'b1;
                  mem_addr  = ld_adj;
                  mem_wdata = req_tdata;
                  ld_pos_in = (ld_next == eff_period) ? '0 : ld_next[ADDR_W-1:0];
                  rd_pos_in = '0;
                  prior_in  = '0;
               end else begin
                  rd_pos_in = rd_adj;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            mem_en   = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            cur_in   = mem_rdata;
            mac_ctl  = '{enable: 1'b1, accumulate: 1'b0};
            mac_a    = $signed({2'b00, tone_ff});
            mac_b    = OPND_W'(mem_rdata);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mac_ctl  = '{enable: 1'b1, accumulate: 1'b1};
            mac_a    = $signed(OPND_W'(18'h10000) - {2'b00, tone_ff});
            mac_b    = OPND_W'(prior_ff);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mac_ctl  = '{enable: 1'b1, accumulate: 1'b0};
            mac_a    = mac_acc[OPND_W+15:16];
            mac_b    = $signed({2'b00, damping_ff});
            state_in = ST_WB;
         end
         ST_WB: begin
            if (wb_fire) begin
               mem_en       = 1'b1;
               mem_we       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = cur_ff;
               prior_in     = cur_ff;
               rd_pos_in    = (rd_next == eff_period) ? '0 : rd_next[ADDR_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_pos_ff    <= '0;
         ld_pos_ff    <= '0;
         prior_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_pos_ff    <= rd_pos_in;
         ld_pos_ff    <= ld_pos_in;
         prior_ff     <= prior_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

   psyn_mac u_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .opnd_a (mac_a),
      .opnd_b (mac_b),
      .acc    (mac_acc)
   );

   psyn_line u_line (
      .clock  (clock),
      .enable (mem_en),
      .write  (mem_we),
      .addr   (mem_addr),
      .wdata  (mem_wdata),
      .rdata  (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/psyn_mac.sv
// ----------------------------------------------------------------------------
// psyn_mac
// Shared signed 18x18 multiplier with a product accumulator register.
// ----------------------------------------------------------------------------
module psyn_mac
   import psyn_pkg::*;
(
   input  logic                      clock,
   input  mac_ctl_type               ctl,
   input  logic signed [OPND_W-1:0]  opnd_a,
   input  logic signed [OPND_W-1:0]  opnd_b,
   output logic signed [PROD_W-1:0]  acc
);

   logic signed [PROD_W-1:0] acc_ff;
   logic signed [PROD_W-1:0] acc_in;
   logic signed [PROD_W-1:0] prod;

   assign prod   = opnd_a * opnd_b;
   assign acc_in = ctl.accumulate ? acc_ff + prod : prod;

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/psyn_line.sv
// ----------------------------------------------------------------------------
// psyn_line
// Single-port delay line memory with registered read data.
// ----------------------------------------------------------------------------
module psyn_line
   import psyn_pkg::*;
(
   input  logic                     clock,
   input  logic                     enable,
   input  logic                     write,
   input  logic [ADDR_W-1:0]        addr,
   input  logic signed [SMP_W-1:0]  wdata,
   output logic signed [SMP_W-1:0]  rdata
);

   logic signed [SMP_W-1:0] mem [MAX_PERIOD];
   logic signed [SMP_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         if (write) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/psyn_checker.sv
// ----------------------------------------------------------------------------
// psyn_checker
// Port-level checks of the plucked string voice, bound to the top level.
// ----------------------------------------------------------------------------
module psyn_checker
   import psyn_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing is offered straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   // a step transfer keeps the block busy
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_STEP |=> !req_tready)
      else $error("accepted during a step");

   // a load transfer creates no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_LOAD && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result after a load");

   // a step result comes no sooner than the arithmetic allows
   a_step_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == KIND_STEP && !rsp_tvalid
      |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result too early");

endmodule

bind plucked_string_synth_core psyn_checker u_psyn_checker (.*);
